// ===== hdl/sbc_pkg.sv =====
package sbc_pkg;

    localparam int COORD_WIDTH = 16;
    localparam int NUM_SLABS   = 6;
    localparam int NUM_REGS    = 6;
    localparam int FW          = COORD_WIDTH + 2;
    localparam int PW          = 2 * FW;
    localparam int ADDR_WIDTH  = $clog2(NUM_REGS) + 2;

    typedef enum logic [2:0] {
        REG_MIN_X = 3'd0,
        REG_MIN_Y = 3'd1,
        REG_MIN_Z = 3'd2,
        REG_MAX_X = 3'd3,
        REG_MAX_Y = 3'd4,
        REG_MAX_Z = 3'd5
    } reg_idx_t;

    typedef logic signed [FW-1:0] frac_t;

    typedef struct packed {
        logic                          vld;
        logic                          alive;
        frac_t                         n1;
        frac_t                         d1;
        frac_t                         n2;
        frac_t                         d2;
        logic [NUM_SLABS-1:0][FW-1:0]  p;
        logic [NUM_SLABS-1:0][FW-1:0]  q;
    } sbc_beat_t;

endpackage

// ===== hdl/sbc_slab.sv =====
module sbc_slab (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              en,
    input  sbc_pkg::frac_t    p,
    input  sbc_pkg::frac_t    q,
    input  sbc_pkg::sbc_beat_t beat_in,
    output sbc_pkg::sbc_beat_t beat_out
);
    import sbc_pkg::*;

    sbc_beat_t             a_reg;
    frac_t                 rn_reg, rd_reg;
    logic                  pneg_reg, ppos_reg, qneg_reg;
    logic signed [PW-1:0]  up_l_reg, up_r_reg, lo_l_reg, lo_r_reg;

    frac_t rn, rd;
    sbc_beat_t b_next;

    always_comb begin
        rn = (p < 0) ? -q : q;
        rd = (p < 0) ? -p : p;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_reg.vld <= 1'b0;
        end else if (en) begin
            a_reg.vld <= beat_in.vld;
        end
        if (en) begin
            a_reg.alive <= beat_in.alive;
            a_reg.n1    <= beat_in.n1;
            a_reg.d1    <= beat_in.d1;
            a_reg.n2    <= beat_in.n2;
            a_reg.d2    <= beat_in.d2;
            a_reg.p     <= beat_in.p;
            a_reg.q     <= beat_in.q;
            rn_reg      <= rn;
            rd_reg      <= rd;
            pneg_reg    <= p < 0;
            ppos_reg    <= p > 0;
            qneg_reg    <= q < 0;
            up_l_reg    <= rn * beat_in.d2;
            up_r_reg    <= beat_in.n2 * rd;
            lo_l_reg    <= rn * beat_in.d1;
            lo_r_reg    <= beat_in.n1 * rd;
        end
    end

    always_comb begin
        b_next = a_reg;
        if (a_reg.alive) begin
            if (pneg_reg) begin
                if (up_l_reg > up_r_reg) begin
                    b_next.alive = 1'b0;
                end else if (lo_l_reg > lo_r_reg) begin
                    b_next.n1 = rn_reg;
                    b_next.d1 = rd_reg;
                end
            end else if (ppos_reg) begin
                if (lo_l_reg < lo_r_reg) begin
                    b_next.alive = 1'b0;
                end else if (up_l_reg < up_r_reg) begin
                    b_next.n2 = rn_reg;
                    b_next.d2 = rd_reg;
                end
            end else if (qneg_reg) begin
                b_next.alive = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            beat_out.vld <= 1'b0;
        end else if (en) begin
            beat_out.vld <= b_next.vld;
        end
        if (en) begin
            beat_out.alive <= b_next.alive;
            beat_out.n1    <= b_next.n1;
            beat_out.d1    <= b_next.d1;
            beat_out.n2    <= b_next.n2;
            beat_out.d2    <= b_next.d2;
            beat_out.p     <= b_next.p;
            beat_out.q     <= b_next.q;
        end
    end

endmodule

// ===== hdl/segment_box_clip_test_3d_unit.sv =====
// Segment versus axis-aligned box touch test (Liang-Barsky, exact integer
// ratios). One segment is accepted per cycle while s_ready is high. One
// setup stage forms the six slab terms, then each slab takes two stages
// (cross products, then compare and narrow). Touching the box counts as a
// hit; an inverted box never hits. The whole pipeline holds while a result
// waits on m_ready. Box bounds sit at byte addresses 0..20.
module segment_box_clip_test_3d_unit (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [sbc_pkg::ADDR_WIDTH-1:0]       paddr,
    input  logic [31:0]                          pwdata,
    output logic [31:0]                          prdata,
    output logic                                 pready,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic signed [sbc_pkg::COORD_WIDTH-1:0] s_start_x,
    input  logic signed [sbc_pkg::COORD_WIDTH-1:0] s_start_y,
    input  logic signed [sbc_pkg::COORD_WIDTH-1:0] s_start_z,
    input  logic signed [sbc_pkg::COORD_WIDTH-1:0] s_end_x,
    input  logic signed [sbc_pkg::COORD_WIDTH-1:0] s_end_y,
    input  logic signed [sbc_pkg::COORD_WIDTH-1:0] s_end_z,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic                                 m_hit
);
    import sbc_pkg::*;

    logic signed [COORD_WIDTH-1:0] box_reg [NUM_REGS];
    reg_idx_t                      ridx;
    logic                          en;
    sbc_beat_t                     st0_next;
    sbc_beat_t                     stage0_reg;
    sbc_beat_t                     stage [NUM_SLABS+1];
    frac_t                         sx, sy, sz, dx, dy, dz;

    assign pready = 1'b1;
    assign ridx   = reg_idx_t'(paddr[ADDR_WIDTH-1:2]);
    assign en      = !m_valid || m_ready;
    assign s_ready = en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            box_reg[REG_MIN_X] <= '0;
            box_reg[REG_MIN_Y] <= '0;
            box_reg[REG_MIN_Z] <= '0;
            box_reg[REG_MAX_X] <= COORD_WIDTH'(32767);
            box_reg[REG_MAX_Y] <= COORD_WIDTH'(32767);
            box_reg[REG_MAX_Z] <= COORD_WIDTH'(32767);
        end else if (psel && penable && pwrite) begin
            unique case (ridx)
                REG_MIN_X, REG_MIN_Y, REG_MIN_Z,
                REG_MAX_X, REG_MAX_Y, REG_MAX_Z: begin
                    box_reg[ridx] <= pwdata[COORD_WIDTH-1:0];
                end
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (ridx)
            REG_MIN_X, REG_MIN_Y, REG_MIN_Z,
            REG_MAX_X, REG_MAX_Y, REG_MAX_Z: begin
                prdata = 32'(box_reg[ridx]);
            end
            default: prdata = '0;
        endcase
    end

    always_comb begin
        sx = FW'(s_start_x);
        sy = FW'(s_start_y);
        sz = FW'(s_start_z);
        dx = FW'(s_end_x) - sx;
        dy = FW'(s_end_y) - sy;
        dz = FW'(s_end_z) - sz;
        st0_next.vld   = s_valid;
        st0_next.alive = 1'b1;
        st0_next.n1    = FW'(0);
        st0_next.d1    = FW'(1);
        st0_next.n2    = FW'(1);
        st0_next.d2    = FW'(1);
        st0_next.p[0]  = -dx;
        st0_next.q[0]  = sx - FW'(box_reg[REG_MIN_X]);
        st0_next.p[1]  = dx;
        st0_next.q[1]  = FW'(box_reg[REG_MAX_X]) - sx;
        st0_next.p[2]  = -dy;
        st0_next.q[2]  = sy - FW'(box_reg[REG_MIN_Y]);
        st0_next.p[3]  = dy;
        st0_next.q[3]  = FW'(box_reg[REG_MAX_Y]) - sy;
        st0_next.p[4]  = -dz;
        st0_next.q[4]  = sz - FW'(box_reg[REG_MIN_Z]);
        st0_next.p[5]  = dz;
        st0_next.q[5]  = FW'(box_reg[REG_MAX_Z]) - sz;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stage0_reg.vld <= 1'b0;
        end else if (en) begin
            stage0_reg.vld <= st0_next.vld;
        end
        if (en) begin
            stage0_reg.alive <= st0_next.alive;
            stage0_reg.n1    <= st0_next.n1;
            stage0_reg.d1    <= st0_next.d1;
            stage0_reg.n2    <= st0_next.n2;
            stage0_reg.d2    <= st0_next.d2;
            stage0_reg.p     <= st0_next.p;
            stage0_reg.q     <= st0_next.q;
        end
    end

    assign stage[0] = stage0_reg;

    for (genvar k = 0; k < NUM_SLABS; k++) begin : g_slab
        sbc_slab u_slab (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .en       (en),
            .p        (frac_t'(stage[k].p[k])),
            .q        (frac_t'(stage[k].q[k])),
            .beat_in  (stage[k]),
            .beat_out (stage[k+1])
        );
    end

    assign m_valid = stage[NUM_SLABS].vld;
    assign m_hit   = stage[NUM_SLABS].alive;

endmodule

// ===== bench/segment_box_clip_test_3d_unit_test.sv =====
`timescale 1ns / 100ps

module segment_box_clip_test_3d_unit_test;
    import sbc_pkg::*;

    localparam int CW = COORD_WIDTH;
    localparam int RANDOM_SEGMENTS = 1200;
    localparam longint CYCLE_LIMIT = 2000000;

    typedef logic signed [CW-1:0] coord_t;

    typedef struct {
        coord_t sx, sy, sz, ex, ey, ez;
        int     want;   // -1: take from predictor
    } segment_row_t;

    logic aclk = 0;
    logic aresetn = 0;
    logic psel = 0, penable = 0, pwrite = 0;
    logic [ADDR_WIDTH-1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;
    logic s_valid = 0;
    logic s_ready;
    coord_t s_start_x = 0, s_start_y = 0, s_start_z = 0;
    coord_t s_end_x = 0, s_end_y = 0, s_end_z = 0;
    logic m_valid;
    logic m_ready = 0;
    logic m_hit;

    segment_box_clip_test_3d_unit uut (.*);

    initial begin
        forever #4 aclk = ~aclk;
    end

    coord_t box_lo [3];
    coord_t box_hi [3];
    bit expected_hits [$];
    int errors = 0;
    int hit_count = 0, miss_count = 0;
    longint cycles = 0;
    bit sink_hold = 0;

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("%0t timeout", $time);
            $display("*** FAILED ***");
            $finish;
        end
    end

    // exact comparison of fractions an/ad vs bn/bd, denominators positive
    function automatic int frac_cmp(longint an, longint ad, longint bn, longint bd);
        longint l, r;
        l = an * bd;
        r = bn * ad;
        return (l > r) ? 1 : ((l < r) ? -1 : 0);
    endfunction

    function automatic bit clip_slab(longint p, longint q, ref longint n1, ref longint d1,
                                     ref longint n2, ref longint d2);
        if (p < 0) begin
            if (frac_cmp(-q, -p, n2, d2) > 0) return 0;
            if (frac_cmp(-q, -p, n1, d1) > 0) begin
                n1 = -q;
                d1 = -p;
            end
        end else if (p > 0) begin
            if (frac_cmp(q, p, n1, d1) < 0) return 0;
            if (frac_cmp(q, p, n2, d2) < 0) begin
                n2 = q;
                d2 = p;
            end
        end else if (q < 0) begin
            return 0;
        end
        return 1;
    endfunction

    function automatic bit predict_hit(coord_t s [3], coord_t e [3]);
        longint n1, d1, n2, d2, d;
        n1 = 0; d1 = 1; n2 = 1; d2 = 1;
        for (int a = 0; a < 3; a++) begin
            d = longint'(e[a]) - longint'(s[a]);
            if (!clip_slab(-d, longint'(s[a]) - longint'(box_lo[a]), n1, d1, n2, d2))
                return 0;
            if (!clip_slab(d, longint'(box_hi[a]) - longint'(s[a]), n1, d1, n2, d2))
                return 0;
        end
        return 1;
    endfunction

    task automatic write_bound(reg_idx_t idx, coord_t value);
        @(posedge aclk);
        psel <= 1; penable <= 0; pwrite <= 1;
        paddr <= ADDR_WIDTH'(4 * int'(idx));
        pwdata <= {{(32-CW){~value[CW-1]}}, value};   // upper bits must be ignored
        @(posedge aclk);
        penable <= 1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        psel <= 0; penable <= 0; pwrite <= 0;
        if (int'(idx) < 3) box_lo[int'(idx)] = value;
        else box_hi[int'(idx) - 3] = value;
    endtask

    task automatic set_box(coord_t lx, coord_t ly, coord_t lz,
                           coord_t hx, coord_t hy, coord_t hz);
        write_bound(REG_MIN_X, lx);
        write_bound(REG_MIN_Y, ly);
        write_bound(REG_MIN_Z, lz);
        write_bound(REG_MAX_X, hx);
        write_bound(REG_MAX_Y, hy);
        write_bound(REG_MAX_Z, hz);
    endtask

    task automatic drain;
        s_valid <= 0;
        while (expected_hits.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    task automatic send_segment(segment_row_t r);
        coord_t s [3];
        coord_t e [3];
        bit h;
        int gap;
        gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 17);
        if (gap != 0) begin
            s_valid <= 0;
            repeat (gap) @(posedge aclk);
        end
        s = '{r.sx, r.sy, r.sz};
        e = '{r.ex, r.ey, r.ez};
        h = predict_hit(s, e);
        if (r.want >= 0 && h != r.want[0]) begin
            $display("%0t predictor disagrees with table: expected %0d, actual %0d",
                     $time, r.want, h);
            errors++;
        end
        if (r.want >= 0) h = r.want[0];
        s_valid <= 1;
        s_start_x <= r.sx; s_start_y <= r.sy; s_start_z <= r.sz;
        s_end_x <= r.ex; s_end_y <= r.ey; s_end_z <= r.ez;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        expected_hits.push_back(h);
    endtask

    function automatic coord_t pick_coord(coord_t lo, coord_t hi);
        int k;
        k = $urandom_range(0, 9);
        if (k < 2) return coord_t'($urandom);
        if (k == 2) return lo;
        if (k == 3) return hi;
        if (k == 4) return coord_t'(lo - 1);
        if (k == 5) return coord_t'(hi + 1);
        return coord_t'($urandom_range(0, 4) + int'(lo) - 2 +
                        $urandom_range(0, int'(hi) - int'(lo) + 4 > 0 ?
                                       int'(hi) - int'(lo) + 4 : 4));
    endfunction

    function automatic segment_row_t random_segment();
        segment_row_t r;
        r.sx = pick_coord(box_lo[0], box_hi[0]);
        r.sy = pick_coord(box_lo[1], box_hi[1]);
        r.sz = pick_coord(box_lo[2], box_hi[2]);
        if ($urandom_range(0, 9) == 0) begin
            r.ex = r.sx; r.ey = r.sy; r.ez = r.sz;
        end else begin
            r.ex = pick_coord(box_lo[0], box_hi[0]);
            r.ey = pick_coord(box_lo[1], box_hi[1]);
            r.ez = pick_coord(box_lo[2], box_hi[2]);
        end
        r.want = -1;
        return r;
    endfunction

    // result side
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (expected_hits.size() == 0) begin
                $display("%0t unexpected beat: expected none, actual hit=%0b", $time, m_hit);
                errors++;
            end else begin
                if (m_hit !== expected_hits[0]) begin
                    $display("%0t hit mismatch: expected %0b, actual %0b",
                             $time, expected_hits[0], m_hit);
                    errors++;
                end
                if (expected_hits[0]) hit_count++;
                else miss_count++;
                void'(expected_hits.pop_front());
            end
        end
    end

    initial begin
        int wait_n;
        @(posedge aclk iff aresetn);
        forever begin
            if (sink_hold) begin
                m_ready <= 0;
                repeat (300) @(posedge aclk);
                sink_hold = 0;
            end else begin
                wait_n = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(0, 17);
                if (wait_n != 0) begin
                    m_ready <= 0;
                    repeat (wait_n) @(posedge aclk);
                end
            end
            m_ready <= 1;
            @(posedge aclk);
            while (!(m_valid && m_ready)) @(posedge aclk);
        end
    end

    localparam coord_t CMAX = 16'sh7fff;
    localparam coord_t CMIN = -16'sh8000;

    segment_row_t directed [] = '{
        '{0, 0, 0, 0, 0, 0, 1},                       // corner point of reset box
        '{CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, 1},     // far corner point
        '{-1, 0, 0, -1, 0, 0, 0},                     // point just outside
        '{CMIN, CMIN, CMIN, CMAX, CMAX, CMAX, 1},     // full diagonal
        '{CMIN, 5, 5, -1, 5, 5, 0},                   // stops short of face
        '{CMIN, 5, 5, 0, 5, 5, 1},                    // ends on face
        '{-10, -10, 5, 10, -10, 5, 0},                // parallel outside
        '{-10, 0, 5, 10, 0, 5, 1},                    // slides along face
        '{-1, 1, 5, 1, -1, 5, 1},                     // through an edge
        '{CMAX, CMIN, CMAX, CMIN, CMAX, CMIN, -1},
        '{CMIN, CMAX, CMIN, CMAX, CMIN, CMAX, -1},
        '{-3, 7, 2, 9, -4, 11, -1},
        '{-21846, 21845, -1, 21845, -21846, 0, -1}
    };

    initial begin
        box_lo = '{0, 0, 0};
        box_hi = '{CMAX, CMAX, CMAX};
        repeat (2) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        foreach (directed[i]) send_segment(directed[i]);
        drain();

        // inverted box on x
        set_box(10, 0, 0, 9, 100, 100);
        send_segment('{9, 5, 5, 10, 5, 5, 0});
        send_segment('{CMIN, 5, 5, CMAX, 5, 5, 0});
        drain();
        set_box(CMIN, CMIN, CMIN, CMAX, CMAX, CMAX);
        send_segment('{CMIN, CMAX, 0, CMAX, CMIN, 0, 1});
        drain();
        set_box(-7, -7, -7, -7, -7, -7);
        send_segment('{-7, -7, -7, -7, -7, -7, 1});
        send_segment('{-14, -14, -14, 0, 0, 0, 1});
        send_segment('{-14, -14, -14, 0, 0, 1, 0});
        drain();

        for (int ph = 0; ph < 6; ph++) begin
            coord_t a, b;
            case (ph)
                0: set_box(-100, -100, -100, 100, 100, 100);
                1: set_box(0, 0, 0, CMAX, CMAX, CMAX);
                2: set_box(CMIN, -50, 300, -20000, 50, 310);
                default: begin
                    a = coord_t'($urandom);
                    b = coord_t'($urandom);
                    if ($urandom_range(0, 4) != 0 && a > b) begin
                        coord_t t;
                        t = a; a = b; b = t;
                    end
                    set_box(a, coord_t'(a - $urandom_range(0, 60) + 20), -30, b, 200, 30);
                end
            endcase
            if (ph == 1) sink_hold = 1;
            repeat (RANDOM_SEGMENTS / 6) send_segment(random_segment());
            drain();
        end

        $display("covered %0d directed and %0d random segments over several boxes",
                 directed.size() + 6, RANDOM_SEGMENTS / 6 * 6);
        $display("results checked: %0d hits, %0d misses", hit_count, miss_count);
        if (errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end
endmodule

// ===== files.f =====
hdl/sbc_pkg.sv
hdl/sbc_slab.sv
hdl/segment_box_clip_test_3d_unit.sv
bench/segment_box_clip_test_3d_unit_test.sv
